/* rtl/chkc_pkg.sv */
// ----------------------------------------------------------------------------
// chkc_pkg
// Types and constants shared by the chained hash key counter modules.
// ----------------------------------------------------------------------------
package chkc_pkg;

   localparam int KEY_W      = 37;
   localparam int COUNT_W    = 16;
   localparam int SIZE_W     = 11;
   localparam int DIV_W      = 17;
   localparam int DIGIT_BITS = 4;
   localparam int OP_W       = 40;
   localparam int STEP_W     = 4;

   // 100000 = 3125 << 5; (key >> 5) / 3125 as (x * (2^32 + RECIP_LO)) >> 44
   localparam int LOW_BITS    = 5;
   localparam int ODD_W       = 12;
   localparam int QUOT_W      = 21;
   localparam int RECIP_SHIFT = 44;

   localparam logic [DIV_W-1:0]   HASH_MOD         = 17'd100000;
   localparam logic [31:0]        HASH_ODD         = 32'd3125;
   localparam logic [31:0]        RECIP_LO         = 32'd1334532239;
   localparam logic [STEP_W-1:0]  BKT_STEPS        = 4'd5;
   localparam logic [SIZE_W-1:0]  TABLE_SIZE_RESET = 11'd11;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_KEY,
      ST_HASH_BKT,
      ST_HEAD,
      ST_NODE,
      ST_ALLOC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic hash_bkt;
      logic head_rd;
      logic node_from_head;
      logic node_from_next;
      logic hit_update;
      logic alloc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic key_done;
      logic hash_done;
      logic head_zero;
      logic hit;
      logic next_zero;
      logic out_free;
   } status_type;

endpackage

/* rtl/chkc_remainder.sv */
// ----------------------------------------------------------------------------
// chkc_remainder
// Restoring remainder unit, four operand bits per cycle, MSB first.
// ----------------------------------------------------------------------------
module chkc_remainder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [chkc_pkg::OP_W-1:0]   operand,
   input  logic [chkc_pkg::DIV_W-1:0]  divisor,
   input  logic [chkc_pkg::STEP_W-1:0] steps,
   output logic                      done,
   output logic [chkc_pkg::DIV_W-1:0]  remainder
);
   import chkc_pkg::*;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   always_comb begin
      logic [DIV_W:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < DIGIT_BITS; i++) begin
         r = {r[DIV_W-1:0], op_ff[OP_W-1-i]};
         if (r >= {1'b0, div_ff}) begin
            r = r - {1'b0, div_ff};
         end
      end
      op_in   = op_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         op_in   = operand;
         div_in  = divisor;
         rem_in  = '0;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         op_in  = op_ff << DIGIT_BITS;
         rem_in = r[DIV_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/chkc_datapath.sv */
// ----------------------------------------------------------------------------
// chkc_datapath
// Bucket head and node memories, hashing, chain pointers and result register.
// ----------------------------------------------------------------------------
module chkc_datapath #(
   parameter int BUCKETS = 1024,
   parameter int ENTRIES = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  chkc_pkg::cmd_type           cmd,
   output chkc_pkg::status_type        status,
   input  logic [chkc_pkg::KEY_W-1:0]    req_key,
   input  logic                        csr_valid,
   input  logic [chkc_pkg::SIZE_W-1:0]   csr_table_size,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [chkc_pkg::COUNT_W-1:0]  rsp_count,
   output logic                        rsp_was_new,
   output logic                        rsp_dropped
);
   import chkc_pkg::*;

   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NODE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LINK_W = $clog2(ENTRIES + 1);
   localparam logic [DIV_W-1:0]  BKT_LIM  = DIV_W'(BUCKETS);
   localparam logic [BKT_W-1:0]  BKT_LAST = BKT_W'(BUCKETS - 1);
   localparam logic [LINK_W-1:0] POOL_MAX = LINK_W'(ENTRIES);

   logic [LINK_W-1:0]  head_mem [BUCKETS];
   logic [KEY_W-1:0]   key_mem [ENTRIES];
   logic [COUNT_W-1:0] count_mem [ENTRIES];
   logic [LINK_W-1:0]  next_mem [ENTRIES];

   logic [SIZE_W-1:0]  table_size_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [3:0]         kmod_stage_ff;
   logic [63:0]        kq_prod_ff;
   logic [QUOT_W-1:0]  kq_quot_ff;
   logic [DIV_W-1:0]   key_mod_ff;
   logic [BKT_W-1:0]   clr_cnt_ff;
   logic [BKT_W-1:0]   bucket_ff;
   logic [LINK_W-1:0]  head_rd_ff;
   logic [NODE_W-1:0]  cur_node_ff;
   logic [KEY_W-1:0]   key_rd_ff;
   logic [COUNT_W-1:0] count_rd_ff;
   logic [LINK_W-1:0]  next_rd_ff;
   logic [LINK_W-1:0]  nodes_used_ff;
   logic [COUNT_W-1:0] res_count_ff;
   logic               res_new_ff;
   logic               res_drop_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_was_new_ff;
   logic               rsp_dropped_ff;

   logic [31:0]        kx;
   logic [64:0]        kq_sum;
   logic [31:0]        kq_rem;
   logic [DIV_W-1:0]   size_eff;
   logic               hash_start;
   logic [OP_W-1:0]    hash_op;
   logic [DIV_W-1:0]   hash_div;
   logic [STEP_W-1:0]  hash_steps;
   logic               hash_done;
   logic [DIV_W-1:0]   hash_rem;
   logic [BKT_W-1:0]   bucket_idx;
   logic [LINK_W-1:0]  head_m1;
   logic [LINK_W-1:0]  next_m1;
   logic [NODE_W-1:0]  node_ra;
   logic               node_re;
   logic               pool_full;
   logic               alloc_we;
   logic [NODE_W-1:0]  alloc_idx;
   logic [LINK_W-1:0]  used_p1;
   logic               head_we;
   logic [BKT_W-1:0]   head_wa;
   logic [LINK_W-1:0]  head_wd;
   logic [COUNT_W-1:0] count_sat;
   logic               count_we;
   logic [NODE_W-1:0]  count_wa;
   logic [COUNT_W-1:0] count_wd;

   always_comb begin
      if (table_size_ff == '0) begin
         size_eff = DIV_W'(1);
      end else if (DIV_W'(table_size_ff) > BKT_LIM) begin
         size_eff = BKT_LIM;
      end else begin
         size_eff = DIV_W'(table_size_ff);
      end
   end

   // key mod 100000 in three stages: product, quotient, remainder
   assign kx     = key_ff[KEY_W-1:LOW_BITS];
   assign kq_sum = {1'b0, kx, 32'd0} + {1'b0, kq_prod_ff};
   assign kq_rem = kx - {11'd0, kq_quot_ff} * HASH_ODD;

   always_ff @(posedge clock) begin
      if (kmod_stage_ff[0]) begin
         kq_prod_ff <= {32'd0, kx} * {32'd0, RECIP_LO};
      end
      if (kmod_stage_ff[1]) begin
         kq_quot_ff <= kq_sum[64:RECIP_SHIFT];
      end
      if (kmod_stage_ff[2]) begin
         key_mod_ff <= {kq_rem[ODD_W-1:0], key_ff[LOW_BITS-1:0]};
      end
   end

   assign hash_start = cmd.hash_bkt;
   assign hash_op    = {3'b000, key_mod_ff, 20'd0};
   assign hash_div   = size_eff;
   assign hash_steps = BKT_STEPS;

   chkc_remainder u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (hash_start),
      .operand   (hash_op),
      .divisor   (hash_div),
      .steps     (hash_steps),
      .done      (hash_done),
      .remainder (hash_rem)
   );

   assign bucket_idx = hash_rem[BKT_W-1:0];
   assign head_m1    = head_rd_ff - LINK_W'(1);
   assign next_m1    = next_rd_ff - LINK_W'(1);
   assign node_re    = cmd.node_from_head | cmd.node_from_next;
   assign node_ra    = cmd.node_from_head ? head_m1[NODE_W-1:0] : next_m1[NODE_W-1:0];

   assign pool_full  = (nodes_used_ff == POOL_MAX);
   assign alloc_we   = cmd.alloc & ~pool_full;
   assign alloc_idx  = nodes_used_ff[NODE_W-1:0];
   assign used_p1    = nodes_used_ff + LINK_W'(1);

   assign count_sat  = (count_rd_ff == COUNT_MAX) ? count_rd_ff : count_rd_ff + COUNT_W'(1);
   assign count_we   = cmd.hit_update | alloc_we;
   assign count_wa   = cmd.hit_update ? cur_node_ff : alloc_idx;
   assign count_wd   = cmd.hit_update ? count_sat : COUNT_W'(1);

   assign head_we    = cmd.clear | alloc_we;
   assign head_wa    = cmd.clear ? clr_cnt_ff : bucket_ff;
   assign head_wd    = cmd.clear ? '0 : used_p1;

   // bucket heads
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      if (cmd.head_rd) begin
         head_rd_ff <= head_mem[bucket_idx];
      end
   end

   // node pool
   always_ff @(posedge clock) begin
      if (alloc_we) begin
         key_mem[alloc_idx]  <= key_ff;
         next_mem[alloc_idx] <= head_rd_ff;
      end
      if (count_we) begin
         count_mem[count_wa] <= count_wd;
      end
      if (node_re) begin
         key_rd_ff   <= key_mem[node_ra];
         count_rd_ff <= count_mem[node_ra];
         next_rd_ff  <= next_mem[node_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff  <= TABLE_SIZE_RESET;
         clr_cnt_ff     <= '0;
         nodes_used_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         kmod_stage_ff  <= '0;
      end else begin
         kmod_stage_ff <= {kmod_stage_ff[2:0], cmd.accept};
         if (csr_valid) begin
            table_size_ff <= csr_table_size;
         end
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + BKT_W'(1);
         end
         if (alloc_we) begin
            nodes_used_ff <= used_p1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         key_ff <= req_key;
      end
      if (cmd.head_rd) begin
         bucket_ff <= bucket_idx;
      end
      if (node_re) begin
         cur_node_ff <= node_ra;
      end
      if (cmd.hit_update) begin
         res_count_ff <= count_sat;
         res_new_ff   <= 1'b0;
         res_drop_ff  <= 1'b0;
      end else if (cmd.alloc) begin
         res_count_ff <= pool_full ? '0 : COUNT_W'(1);
         res_new_ff   <= ~pool_full;
         res_drop_ff  <= pool_full;
      end
      if (cmd.emit) begin
         rsp_count_ff   <= res_count_ff;
         rsp_was_new_ff <= res_new_ff;
         rsp_dropped_ff <= res_drop_ff;
      end
   end

   assign status.clr_last  = (clr_cnt_ff == BKT_LAST);
   assign status.key_done  = kmod_stage_ff[3];
   assign status.hash_done = hash_done;
   assign status.head_zero = (head_rd_ff == '0);
   assign status.hit       = (key_rd_ff == key_ff);
   assign status.next_zero = (next_rd_ff == '0);
   assign status.out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_was_new = rsp_was_new_ff;
   assign rsp_dropped = rsp_dropped_ff;

`ifndef SYNTHESIS
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      nodes_used_ff <= POOL_MAX)
      else $error("node pool count beyond capacity");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      alloc_we |=> nodes_used_ff == $past(nodes_used_ff) + LINK_W'(1))
      else $error("allocation did not advance the pool count");

   a_drop_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dropped_ff |-> rsp_count_ff == '0 && !rsp_was_new_ff)
      else $error("dropped item carries a count or new flag");
`endif

endmodule

/* rtl/chkc_controller.sv */
// ----------------------------------------------------------------------------
// chkc_controller
// Sequencer: head clear pass, hashing, chain walk, update and result hand-off.
// ----------------------------------------------------------------------------
module chkc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  chkc_pkg::status_type status,
   output chkc_pkg::cmd_type    cmd
);
   import chkc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_HASH_KEY;
         end
         ST_HASH_KEY: begin
            if (status.key_done) state_in = ST_HASH_BKT;
         end
         ST_HASH_BKT: begin
            if (status.hash_done) state_in = ST_HEAD;
         end
         ST_HEAD: begin
            state_in = status.head_zero ? ST_ALLOC : ST_NODE;
         end
         ST_NODE: begin
            if (status.hit) begin
               state_in = ST_EMIT;
            end else if (status.next_zero) begin
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_HASH_KEY: begin
            cmd.hash_bkt = status.key_done;
         end
         ST_HASH_BKT: begin
            cmd.head_rd = status.hash_done;
         end
         ST_HEAD: begin
            cmd.node_from_head = ~status.head_zero;
         end
         ST_NODE: begin
            cmd.hit_update     = status.hit;
            cmd.node_from_next = ~status.hit & ~status.next_zero;
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.hit_update, cmd.alloc, cmd.node_from_next, cmd.clear}))
      else $error("conflicting pool commands");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_HASH_KEY && !cmd.accept)
      else $error("item accepted without starting the hash");

   a_emit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !cmd.emit && state_ff == ST_IDLE)
      else $error("result handed off twice");
`endif

endmodule

/* rtl/chained_hash_key_counter_unit.sv */
// Hashing: key mod 100000, then the bucket index.
// Items: one at a time, next accepted once the result is registered; a
// stalled result holds the unit.
// Reset: a clearing pass over the bucket head memory, no items taken
// meanwhile; table_size returns to 11, node pool empties.
// ----------------------------------------------------------------------------
// chained_hash_key_counter_unit
// Separate-chaining hash table that counts occurrences of decimal keys.
// ----------------------------------------------------------------------------
module chained_hash_key_counter_unit #(
   parameter int BUCKETS = 1024,
   parameter int ENTRIES = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [chkc_pkg::KEY_W-1:0]    req_key,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [chkc_pkg::COUNT_W-1:0]  rsp_count,
   output logic                        rsp_was_new,
   output logic                        rsp_dropped,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [chkc_pkg::SIZE_W-1:0]   csr_table_size
);
   import chkc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   chkc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   chkc_datapath #(
      .BUCKETS (BUCKETS),
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_key        (req_key),
      .csr_valid      (csr_valid),
      .csr_table_size (csr_table_size),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_count      (rsp_count),
      .rsp_was_new    (rsp_was_new),
      .rsp_dropped    (rsp_dropped)
   );

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the chained hash key counter unit.
// The bench sends decimal keys and checks every result against a local
// copy of the bucket chains and the node pool. The tests cover the field
// extremes, colliding keys, table sizes at and beyond their limits, a count
// run on one key and the node pool filled until keys are dropped.
// The random phases mix repeated, colliding and fresh keys. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import chkc_pkg::*;

   localparam int BUCKETS = 1024;
   localparam int ENTRIES = 1024;
   localparam longint unsigned DEC_KEY_SPAN = 64'd100000000000;
   localparam longint unsigned LOW_DIGITS   = 64'd100000;
   localparam int unsigned COUNT_RUN = 12;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               was_new;
      logic               dropped;
   } tally_type;

   logic                clock;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   key_type             req_key        = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [COUNT_W-1:0]  rsp_count;
   logic                rsp_was_new;
   logic                rsp_dropped;
   logic                csr_valid      = 1'b0;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_table_size = '0;

   // local copy of the hash table
   int unsigned         buckets_cfg = TABLE_SIZE_RESET;
   int unsigned         chain_head [BUCKETS];
   key_type             slot_key   [ENTRIES];
   logic [COUNT_W-1:0]  slot_count [ENTRIES];
   int unsigned         slot_next  [ENTRIES];
   int unsigned         slots_used = 0;

   tally_type           expected_tallies [$];
   key_type             known_keys [$];
   int                  mismatches = 0;
   int                  stall_left = 0;
   bit                  no_gaps    = 1'b0;

   chained_hash_key_counter_unit #(
      .BUCKETS(BUCKETS),
      .ENTRIES(ENTRIES)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_count      (rsp_count),
      .rsp_was_new    (rsp_was_new),
      .rsp_dropped    (rsp_dropped),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_table_size (csr_table_size)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // count one key: walk its chain, bump, allocate or drop
   function automatic tally_type tally_key(input key_type k);
      tally_type   t;
      int unsigned size;
      int unsigned b;
      int unsigned link;
      int unsigned steps;
      int unsigned n;
      size = buckets_cfg;
      if (size < 1) size = 1;
      if (size > BUCKETS) size = BUCKETS;
      b = int'((64'(k) % 64'(HASH_MOD)) % 64'(size));
      link = chain_head[b];
      steps = 0;
      t = '0;
      while (link != 0 && link <= ENTRIES && steps < ENTRIES) begin
         n = link - 1;
         if (slot_key[n] == k) begin
            if (slot_count[n] != COUNT_MAX) slot_count[n] = slot_count[n] + 1'b1;
            t.count = slot_count[n];
            return t;
         end
         link = slot_next[n];
         steps++;
      end
      if (slots_used >= ENTRIES) begin
         t.dropped = 1'b1;
         return t;
      end
      n = slots_used;
      slot_key[n]   = k;
      slot_count[n] = 1;
      slot_next[n]  = chain_head[b];
      chain_head[b] = n + 1;
      slots_used    = n + 1;
      t.count   = 1;
      t.was_new = 1'b1;
      return t;
   endfunction

   function automatic key_type random_decimal_key();
      return key_type'({$urandom(), $urandom()} % DEC_KEY_SPAN);
   endfunction

   function automatic key_type fresh_key();
      if ($urandom_range(0, 7) == 0) return key_type'({$urandom(), $urandom()});
      return random_decimal_key();
   endfunction

   function automatic key_type pick_key();
      int unsigned     r;
      longint unsigned base;
      r = $urandom_range(0, 99);
      if (known_keys.size() > 0 && r < 60) begin
         base = 64'(known_keys[$urandom_range(0, known_keys.size() - 1)]);
         if (r < 45) return key_type'(base);
         // same low five digits, so same bucket
         return key_type'((64'(random_decimal_key()) / LOW_DIGITS) * LOW_DIGITS
                          + base % LOW_DIGITS);
      end
      return fresh_key();
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   task automatic send_key(input key_type k);
      int        gap;
      tally_type t;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key   <= k;
      do @(posedge clock); while (req_stall);
      t = tally_key(k);
      if (t.was_new) known_keys.push_back(k);
      expected_tallies.push_back(t);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_tallies.size() != 0);
   endtask

   task automatic write_table_size(input logic [SIZE_W-1:0] v);
      wait_idle();
      repeat (pick_gap()) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_table_size <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      buckets_cfg = v;
   endtask

   task automatic check_tally();
      tally_type want;
      if (expected_tallies.size() == 0) begin
         report_mismatch($sformatf("unexpected result, count %0d", rsp_count));
         return;
      end
      want = expected_tallies.pop_front();
      if (rsp_count !== want.count)
         report_mismatch($sformatf("count %0d, expected %0d", rsp_count, want.count));
      if (rsp_was_new !== want.was_new)
         report_mismatch($sformatf("was_new %b, expected %b", rsp_was_new, want.was_new));
      if (rsp_dropped !== want.dropped)
         report_mismatch($sformatf("dropped %b, expected %b", rsp_dropped, want.dropped));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_tally();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
         end
      end
   end

   // reset size of 11; extremes of the key, collisions on the low digits
   task automatic test_directed_keys();
      send_key('0);
      send_key('0);
      send_key(37'd99999999999);
      send_key('1);
      send_key(37'd100000000000);
      send_key(37'd12300000);
      send_key('0);
      send_key(37'd11);
      send_key(37'd23);
      wait_idle();
   endtask

   // sizes 0 and 2047 clamp; a new mapping leaves old chains in place
   task automatic test_table_size_extremes();
      write_table_size('0);
      send_key(37'd5);
      send_key(37'd5);
      send_key('0);
      write_table_size('1);
      send_key(37'd99999);
      send_key(37'd1023);
      send_key(37'd1024);
      write_table_size(11'd1024);
      send_key(37'd99999);
      send_key('1);
      write_table_size(11'd1);
      send_key(37'd7);
      write_table_size(11'd13);
      send_key(37'd23);
      send_key(37'd23);
      wait_idle();
   endtask

   // one key back to back, its count climbing each time
   task automatic test_count_run();
      no_gaps = 1'b1;
      write_table_size(11'd1021);
      for (int unsigned i = 0; i < COUNT_RUN; i++) send_key(37'd54321098765);
      wait_idle();
      no_gaps = 1'b0;
   endtask

   task automatic test_random_mix();
      int unsigned sizes [9] = '{2, 1021, 7, 1, 509, 97, 1024, 11, 3};
      for (int p = 0; p < 6; p++) begin
         if ($urandom_range(0, 4) == 0) write_table_size(SIZE_W'($urandom_range(0, 2047)));
         else write_table_size(SIZE_W'(sizes[$urandom_range(0, 8)]));
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < 20; i++) send_key(pick_key());
      end
      wait_idle();
      no_gaps = 1'b0;
   endtask

   // fill the node pool, then new keys are dropped while hits still count
   task automatic test_pool_exhaustion();
      write_table_size(11'd1024);
      while (slots_used < ENTRIES) send_key(fresh_key());
      send_key(fresh_key());
      for (int i = 0; i < 20; i++) send_key(pick_key());
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_keys();
      test_table_size_extremes();
      test_count_run();
      test_random_mix();
      test_pool_exhaustion();
      wait_idle();
      repeat (200) @(posedge clock);
      if (expected_tallies.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_tallies.size()));
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
